// ----- hw/rtl/acfb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package acfb_pkg;

  localparam int STATUS_DEPTH_DEF = 14;
  localparam int DATA_BYTES       = 16;
  localparam int FRAME_BYTES      = DATA_BYTES + 6;

  localparam logic [7:0] WAKE_BYTE  = 8'h00;
  localparam logic [7:0] START_BYTE = 8'h16;
  localparam logic [7:0] CMD_BYTE   = 8'h02;
  localparam logic [7:0] LEN_BYTE   = 8'(DATA_BYTES);
  localparam logic [7:0] END_BYTE   = 8'h08;
  localparam logic [7:0] SUM_INIT   = 8'(START_BYTE + CMD_BYTE + LEN_BYTE);
  localparam logic [7:0] TEMP_BIAS  = 8'h10;
  localparam logic [7:0] POWER_MARK = 8'h20;

  // size that gets the remapped status layout
  localparam logic [3:0] REMAP_SIZE = 4'd4;

  // frame positions
  localparam logic [4:0] POS_WAKE  = 5'd0;
  localparam logic [4:0] POS_START = 5'd1;
  localparam logic [4:0] POS_CMD   = 5'd2;
  localparam logic [4:0] POS_LEN   = 5'd3;
  localparam logic [4:0] POS_DATA  = 5'd4;
  localparam logic [4:0] POS_SUM   = 5'(FRAME_BYTES - 2);
  localparam logic [4:0] POS_END   = 5'(FRAME_BYTES - 1);

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_SET  = 2'd1;
  localparam logic [1:0] MODE_SEND = 2'd2;

  localparam logic [1:0] RES_SENT    = 2'd0;
  localparam logic [1:0] RES_NONE    = 2'd1;
  localparam logic [1:0] RES_BADSIZE = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  status_index;
    logic [7:0]  status_value;
    logic [15:0] op_code;
    logic [3:0]  status_count;
  } cmd_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] tx_byte;
    logic [1:0] send_result;
    logic       last;
  } txd_t;

  // status slot feeding the data byte at a frame position
  function automatic logic [3:0] status_slot(input logic [4:0] pos, input logic remap);
    logic [3:0] j;
    logic [3:0] slot;
    j = 4'(pos - POS_DATA);
    if (remap) begin
      slot = (j == 4'd12) ? 4'd0 : 4'(j - 4'd1);
    end else begin
      slot = 4'(j - 4'd2);
    end
    return slot;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/acfb_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module acfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 14,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/aircon_command_frame_builder_top.sv -----
// Load and set requests are applied when accepted; stall is high while a send
// is running. A valid send emits 22 bytes, one per cycle when the sink does not
// stall; the request sets the send state, which registers the first byte, and the
// input stalls through the end byte. The status RAM is read one frame position ahead.
// Invalid sends give one result the cycle after the request. Synchronous reset
// clears pending code/size and the per-entry valid bits (store reads as zero).
`timescale 1ns / 1ps
`default_nettype none

module aircon_command_frame_builder_top
  import acfb_pkg::*;
#(
  parameter int STATUS_DEPTH = STATUS_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  input  wire cmd_t cmd,
  output logic      txd_valid,
  input  wire logic txd_stall,
  output txd_t      txd
);

  localparam int AW = (STATUS_DEPTH > 1) ? $clog2(STATUS_DEPTH) : 1;
  localparam logic [3:0] SIZE_MAX = 4'(STATUS_DEPTH);

  typedef enum logic {ST_IDLE, ST_SEND} state_t;

  state_t                  state;
  logic [4:0]              pos;
  logic [7:0]              sum;
  logic [15:0]             pend_code;
  logic [3:0]              pend_size;
  logic [STATUS_DEPTH-1:0] slot_valid;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           rd_addr_q;
  logic [7:0]              ram_rdata;
  logic [7:0]              mem_byte;
  logic [7:0]              data_byte;
  logic [7:0]              cur_byte;
  logic [3:0]              j;
  logic                    remap;
  logic                    out_free;
  logic                    emit;
  logic                    accept;
  logic                    load_we;
  logic                    out_load;
  logic [4:0]              rd_pos;

  assign out_free  = !txd_valid || !txd_stall;
  assign cmd_stall = (state != ST_IDLE) || !out_free;
  assign accept    = cmd_valid && !cmd_stall;
  assign emit      = (state == ST_SEND) && out_free;
  assign load_we   = accept && (cmd.mode == MODE_LOAD) && (cmd.status_index < SIZE_MAX);
  assign remap     = (pend_size == REMAP_SIZE);
  // a result is registered for a frame byte or a rejected send
  assign out_load  = emit || (accept && (cmd.mode == MODE_SEND) && (pend_size < REMAP_SIZE));

  // address the slot of the position shown next cycle
  assign rd_pos  = emit ? 5'(pos + 5'd1) : pos;
  assign rd_addr = AW'(status_slot(rd_pos, remap));

  acfb_ram #(
    .WIDTH(8),
    .DEPTH(STATUS_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (load_we),
    .waddr(AW'(cmd.status_index)),
    .wdata(cmd.status_value),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
  end

  assign mem_byte = ((rd_addr_q < AW'(STATUS_DEPTH - 1) || rd_addr_q == AW'(STATUS_DEPTH - 1))
                     && slot_valid[rd_addr_q]) ? ram_rdata : 8'h00;

  assign j = 4'(pos - POS_DATA);

  always_comb begin
    data_byte = 8'h00;
    if (j == 4'd0) begin
      data_byte = pend_code[7:0];
    end else if (j == 4'd1) begin
      data_byte = pend_code[15:8];
    end else if (remap) begin
      case (j)
        4'd2, 4'd4: data_byte = mem_byte;
        4'd3:       data_byte = 8'(mem_byte - TEMP_BIAS);
        4'd5:       data_byte = 8'h01;
        4'd12:      data_byte = POWER_MARK | mem_byte;
        default:    data_byte = 8'h00;
      endcase
    end else if (4'(j - 4'd2) < pend_size) begin
      data_byte = mem_byte;
    end
  end

  always_comb begin
    unique case (pos)
      POS_WAKE:  cur_byte = WAKE_BYTE;
      POS_START: cur_byte = START_BYTE;
      POS_CMD:   cur_byte = CMD_BYTE;
      POS_LEN:   cur_byte = LEN_BYTE;
      POS_SUM:   cur_byte = sum;
      POS_END:   cur_byte = END_BYTE;
      default:   cur_byte = data_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      txd_valid  <= 1'b0;
      pend_code  <= '0;
      pend_size  <= '0;
      pos        <= '0;
      slot_valid <= '0;
    end else begin
      if (out_load) begin
        txd_valid <= 1'b1;
      end else if (!txd_stall) begin
        txd_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (cmd.mode)
              MODE_LOAD: begin
                if (load_we) begin
                  slot_valid[AW'(cmd.status_index)] <= 1'b1;
                end
              end
              MODE_SET: begin
                pend_code <= cmd.op_code;
                pend_size <= (cmd.status_count > SIZE_MAX) ? SIZE_MAX : cmd.status_count;
              end
              MODE_SEND: begin
                if (pend_size == 4'd0) begin
                  txd <= '{has_byte: 1'b0, tx_byte: 8'h00,
                           send_result: RES_NONE, last: 1'b1};
                end else if (pend_size < REMAP_SIZE) begin
                  txd <= '{has_byte: 1'b0, tx_byte: 8'h00,
                           send_result: RES_BADSIZE, last: 1'b1};
                end else begin
                  state <= ST_SEND;
                  pos   <= POS_WAKE;
                  sum   <= SUM_INIT;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SEND: begin
          if (out_free) begin
            txd <= '{has_byte: 1'b1, tx_byte: cur_byte,
                     send_result: RES_SENT, last: (pos == POS_END)};
            if (pos >= POS_DATA && pos < POS_SUM) begin
              sum <= 8'(sum + data_byte);
            end
            if (pos == POS_END) begin
              state     <= ST_IDLE;
              pend_size <= '0;
              pos       <= '0;
            end else begin
              pos <= 5'(pos + 5'd1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEND |-> pos <= POS_END)
    else $error("frame position out of range");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |-> state == ST_IDLE && out_free)
    else $error("request taken while busy");

  a_last_is_end: assert property (@(posedge clk) disable iff (rst)
    txd_valid && txd.has_byte && txd.last |-> txd.tx_byte == END_BYTE)
    else $error("last frame byte is not the end byte");

  a_size_cleared: assert property (@(posedge clk) disable iff (rst)
    emit && pos == POS_END |=> pend_size == 4'd0 && state == ST_IDLE)
    else $error("pending size kept after send");

  a_send_size_ok: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEND |-> pend_size >= REMAP_SIZE)
    else $error("frame running with invalid size");
`endif

endmodule

`default_nettype wire
